/* src/rbsi_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the ray/box slab test.
// Depends on nothing; imported by ray_box_slab_intersection, rbsi_checker and tb.
package rbsi_pkg;

   localparam int CW     = 32;          // coordinate width
   localparam int FB     = 16;          // fractional bits
   localparam int MW     = CW + 1;      // width of corner - origin magnitudes
   localparam int QW     = CW - 1;      // quotient bits kept by the divider
   localparam int IW     = CW - 1 - FB; // integer quotient bits
   localparam int OW     = CW + IW;     // width of the divider overflow compare
   localparam int TW     = CW + 1;      // distance width, holds the open ends
   localparam int PW     = 2 * CW;      // product width
   localparam int SW     = CW + 3;      // width of the final sum
   localparam int ADDR_W = 5;
   localparam int NDIV   = 6;

   localparam logic signed [TW-1:0] TPOS   = {2'b01, {(CW-1){1'b0}}};
   localparam logic signed [TW-1:0] TNEG   = {2'b10, {(CW-1){1'b1}}};
   localparam logic signed [TW-1:0] TSMAX  = {2'b00, {(CW-1){1'b1}}};
   localparam logic signed [TW-1:0] TSMIN  = {2'b11, {(CW-1){1'b0}}};
   localparam logic [PW-1:0]        MLIM   = {{(PW-CW-1){1'b0}}, 1'b1, {CW{1'b0}}};

   localparam logic [1:0] NRM_NEG  = 2'b11;
   localparam logic [1:0] NRM_POS  = 2'b01;
   localparam logic [1:0] NRM_NONE = 2'b00;

   typedef enum logic [2:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][CW-1:0] dir;
   } ray_type;

   typedef struct packed {
      logic [MW-1:0] an;
      logic [CW-1:0] ad;
      logic [CW-1:0] rem;
      logic [QW-1:0] q;
      logic          neg;
      logic          ovf;
   } div_type;

   typedef struct packed {
      logic signed [TW-1:0] tn;
      logic signed [TW-1:0] tf;
      logic [1:0]           ns;
   } slab_type;

   typedef struct packed {
      logic signed [TW-1:0] tmin;
      logic signed [TW-1:0] tmax;
      logic [2:0][1:0]      nrm;
      logic                 miss;
   } merge_type;

   // Saturate a wide signed value to the coordinate range.
   function automatic logic [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi_lim;
      logic signed [SW-1:0] lo_lim;
      hi_lim = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo_lim = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
      if (v > hi_lim) begin
         return hi_lim[CW-1:0];
      end else if (v < lo_lim) begin
         return lo_lim[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

endpackage

/* src/ray_box_slab_intersection.sv */
`timescale 1ns / 1ps
// Pipelined ray versus axis-aligned box test by the slab method.
// Depends on rbsi_pkg for widths, register codes and stage types.
//
// Usage. The box corners are six 32-bit signed Q16.16 registers written
// over the APB-style port (min x, y, z at byte addresses 0, 4, 8; max x,
// y, z at 12, 16, 20). Write them only while no ray is in flight.
// Each word on the req channel is one ray (origin and direction); each
// word on the rsp channel is its result: a hit flag, the entry point and
// the entry face normal, or all zeros on a miss.
// The path from an accepted ray to rsp holds 38 register stages.
// Throughput is one ray per cycle while no shown result is stalled:
// six restoring dividers, one quotient bit per stage over 31 stages,
// followed by slab, merge and multiply stages, all move together.
// When rsp_stall is held while a result is shown, the whole pipeline
// freezes and req_stall rises in the same cycle; nothing is dropped or
// repeated. Reset clears all valid bits and the box registers to zero.
module ray_box_slab_intersection
   import rbsi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CW-1:0]       req_origin_x,
   input  logic [CW-1:0]       req_origin_y,
   input  logic [CW-1:0]       req_origin_z,
   input  logic [CW-1:0]       req_dir_x,
   input  logic [CW-1:0]       req_dir_y,
   input  logic [CW-1:0]       req_dir_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [CW-1:0]       rsp_hit_point_x,
   output logic [CW-1:0]       rsp_hit_point_y,
   output logic [CW-1:0]       rsp_hit_point_z,
   output logic [1:0]          rsp_normal_x,
   output logic [1:0]          rsp_normal_y,
   output logic [1:0]          rsp_normal_z,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CW-1:0]       pwdata,
   output logic [CW-1:0]       prdata,
   output logic                pready
);

   // ------------------------------------------------------------------
   // Box registers.
   // ------------------------------------------------------------------
   logic [CW-1:0] box_ff [0:NDIV-1];
   reg_idx_type   csr_idx;

   assign csr_idx = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NDIV; r++) begin
            box_ff[r] <= '0;
         end
      end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] < 3'(NDIV))) begin
         box_ff[paddr[ADDR_W-1:2]] <= pwdata;
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_X: prdata = box_ff[0];
         REG_MIN_Y: prdata = box_ff[1];
         REG_MIN_Z: prdata = box_ff[2];
         REG_MAX_X: prdata = box_ff[3];
         REG_MAX_Y: prdata = box_ff[4];
         REG_MAX_Z: prdata = box_ff[5];
         default:   prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Global advance: every stage moves unless a shown result is stalled.
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // Setup: differences, magnitudes, overflow and parallel checks.
   // ------------------------------------------------------------------
   ray_type       ray_in;
   div_type       setup_in [0:NDIV-1];
   logic [2:0]    par_in;
   logic [2:0]    pmiss_in;

   assign ray_in.org = {req_origin_z, req_origin_y, req_origin_x};
   assign ray_in.dir = {req_dir_z, req_dir_y, req_dir_x};

   always_comb begin
      logic signed [MW-1:0] o_w;
      logic signed [MW-1:0] num;
      logic [CW-1:0]        ad;
      logic [MW-1:0]        an;
      for (int ax = 0; ax < 3; ax++) begin
         o_w = {ray_in.org[ax][CW-1], ray_in.org[ax]};
         ad  = ray_in.dir[ax][CW-1] ? CW'(-ray_in.dir[ax]) : ray_in.dir[ax];
         par_in[ax]   = (ray_in.dir[ax] == '0);
         pmiss_in[ax] = ($signed(ray_in.org[ax]) < $signed(box_ff[ax])) ||
                        ($signed(ray_in.org[ax]) > $signed(box_ff[3+ax]));
         for (int e = 0; e < 2; e++) begin
            num = (e == 0) ? ($signed({box_ff[ax][CW-1], box_ff[ax]}) - o_w)
                           : ($signed({box_ff[3+ax][CW-1], box_ff[3+ax]}) - o_w);
            an  = num[MW-1] ? MW'(-num) : MW'(num);
            setup_in[2*ax+e].an  = an;
            setup_in[2*ax+e].ad  = ad;
            setup_in[2*ax+e].rem = CW'(an >> IW);
            setup_in[2*ax+e].q   = '0;
            setup_in[2*ax+e].neg = num[MW-1] ^ ray_in.dir[ax][CW-1];
            setup_in[2*ax+e].ovf = {{(OW-MW){1'b0}}, an} >= {ad, {IW{1'b0}}};
         end
      end
   end

   // ------------------------------------------------------------------
   // Divider pipeline: one quotient bit per stage, six lanes.
   // ------------------------------------------------------------------
   div_type    div_ff   [0:QW][0:NDIV-1];
   div_type    div_in   [1:QW][0:NDIV-1];
   ray_type    dray_ff  [0:QW];
   logic [2:0] dpar_ff  [0:QW];
   logic [2:0] dpmiss_ff[0:QW];
   logic       dvld_ff  [0:QW];

   always_comb begin
      logic [MW+FB-1:0] nf;
      logic [CW:0]      tr;
      int               bi;
      for (int s = 0; s < QW; s++) begin
         bi = QW - 1 - s;
         for (int k = 0; k < NDIV; k++) begin
            div_in[s+1][k] = div_ff[s][k];
            nf = {div_ff[s][k].an, {FB{1'b0}}};
            tr = {div_ff[s][k].rem, nf[bi]};
            if (tr >= {1'b0, div_ff[s][k].ad}) begin
               div_in[s+1][k].rem   = CW'(tr - {1'b0, div_ff[s][k].ad});
               div_in[s+1][k].q[bi] = 1'b1;
            end else begin
               div_in[s+1][k].rem = CW'(tr);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) begin
            dvld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         dvld_ff[0] <= req_valid;
         for (int s = 1; s <= QW; s++) begin
            dvld_ff[s] <= dvld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dray_ff[0]   <= ray_in;
         dpar_ff[0]   <= par_in;
         dpmiss_ff[0] <= pmiss_in;
         for (int k = 0; k < NDIV; k++) begin
            div_ff[0][k] <= setup_in[k];
         end
         for (int s = 1; s <= QW; s++) begin
            dray_ff[s]   <= dray_ff[s-1];
            dpar_ff[s]   <= dpar_ff[s-1];
            dpmiss_ff[s] <= dpmiss_ff[s-1];
            for (int k = 0; k < NDIV; k++) begin
               div_ff[s][k] <= div_in[s][k];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Slab stage: signed, saturated distances, swap and normal sign.
   // ------------------------------------------------------------------
   slab_type  slab_in  [0:2];
   slab_type  slab_ff  [0:2];
   logic      smiss_in;
   logic      smiss_ff;
   ray_type   sray_ff;
   logic      svld_ff;

   always_comb begin
      logic signed [TW-1:0] tq [0:1];
      smiss_in = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
         for (int e = 0; e < 2; e++) begin
            if (div_ff[QW][2*ax+e].ovf) begin
               tq[e] = div_ff[QW][2*ax+e].neg ? TSMIN : TSMAX;
            end else if (div_ff[QW][2*ax+e].neg) begin
               tq[e] = -$signed({2'b00, div_ff[QW][2*ax+e].q});
            end else begin
               tq[e] = $signed({2'b00, div_ff[QW][2*ax+e].q});
            end
         end
         if (dpar_ff[QW][ax]) begin
            slab_in[ax].tn = TNEG;
            slab_in[ax].tf = TPOS;
            slab_in[ax].ns = NRM_NEG;
            if (dpmiss_ff[QW][ax]) begin
               smiss_in = 1'b1;
            end
         end else if (tq[0] > tq[1]) begin
            slab_in[ax].tn = tq[1];
            slab_in[ax].tf = tq[0];
            slab_in[ax].ns = NRM_POS;
         end else begin
            slab_in[ax].tn = tq[0];
            slab_in[ax].tf = tq[1];
            slab_in[ax].ns = NRM_NEG;
         end
      end
   end

   // ------------------------------------------------------------------
   // Merge stages: x with y, then the result with z.
   // ------------------------------------------------------------------
   merge_type ym_in;
   merge_type ym_ff;
   slab_type  yz_ff;
   ray_type   yray_ff;
   logic      yvld_ff;
   merge_type zm_in;
   logic [CW-1:0] ztsat_in;
   logic [CW-1:0] ztsat_ff;
   merge_type zm_ff;
   ray_type   zray_ff;
   logic      zvld_ff;

   always_comb begin
      ym_in.tmin = slab_ff[0].tn;
      ym_in.tmax = slab_ff[0].tf;
      ym_in.nrm  = {NRM_NONE, NRM_NONE, slab_ff[0].ns};
      ym_in.miss = smiss_ff;
      if (ym_in.tmin > slab_ff[1].tf || slab_ff[1].tn > ym_in.tmax) begin
         ym_in.miss = 1'b1;
      end
      if (slab_ff[1].tn > slab_ff[0].tn) begin
         ym_in.tmin = slab_ff[1].tn;
         ym_in.nrm  = {NRM_NONE, slab_ff[1].ns, NRM_NONE};
      end
      if (slab_ff[1].tf < slab_ff[0].tf) begin
         ym_in.tmax = slab_ff[1].tf;
      end
   end

   always_comb begin
      zm_in = ym_ff;
      if (ym_ff.tmin > yz_ff.tf || yz_ff.tn > ym_ff.tmax) begin
         zm_in.miss = 1'b1;
      end
      if (yz_ff.tn > ym_ff.tmin) begin
         zm_in.tmin = yz_ff.tn;
         zm_in.nrm  = {yz_ff.ns, NRM_NONE, NRM_NONE};
      end
      if (yz_ff.tf < ym_ff.tmax) begin
         zm_in.tmax = yz_ff.tf;
      end
      ztsat_in = sat_cw(SW'(zm_in.tmin));
   end

   // ------------------------------------------------------------------
   // Entry point: magnitude product, scale and clamp, then add origin.
   // ------------------------------------------------------------------
   logic [2:0][PW-1:0]   prod_in;
   logic [2:0][PW-1:0]   prod_ff;
   logic [2:0]           pneg_in;
   logic [2:0]           pneg_ff;
   merge_type            pm_ff;
   ray_type              pray_ff;
   logic                 pvld_ff;
   logic signed [CW+1:0] off_in  [0:2];
   logic signed [CW+1:0] off_ff  [0:2];
   merge_type            qm_ff;
   ray_type              qray_ff;
   logic                 qvld_ff;

   always_comb begin
      logic [CW-1:0] am;
      logic [CW-1:0] bm;
      bm = ztsat_ff[CW-1] ? CW'(-ztsat_ff) : ztsat_ff;
      for (int ax = 0; ax < 3; ax++) begin
         am = zray_ff.dir[ax][CW-1] ? CW'(-zray_ff.dir[ax]) : zray_ff.dir[ax];
         prod_in[ax] = {{CW{1'b0}}, am} * {{CW{1'b0}}, bm};
         pneg_in[ax] = zray_ff.dir[ax][CW-1] ^ ztsat_ff[CW-1];
      end
   end

   always_comb begin
      logic [PW-1:0] m;
      for (int ax = 0; ax < 3; ax++) begin
         m = prod_ff[ax] >> FB;
         if (m > MLIM) begin
            m = MLIM;
         end
         off_in[ax] = pneg_ff[ax] ? -$signed({1'b0, m[CW:0]}) : $signed({1'b0, m[CW:0]});
      end
   end

   logic [CW-1:0] pt_in [0:2];

   always_comb begin
      logic signed [SW-1:0] sum;
      for (int ax = 0; ax < 3; ax++) begin
         sum = SW'($signed(qray_ff.org[ax])) + SW'(off_ff[ax]);
         pt_in[ax] = qm_ff.miss ? '0 : sat_cw(sum);
      end
   end

   // ------------------------------------------------------------------
   // Back-end registers.
   // ------------------------------------------------------------------
   logic          rsp_hit_ff;
   logic [CW-1:0] rsp_pt_ff  [0:2];
   logic [1:0]    rsp_nrm_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         svld_ff      <= 1'b0;
         yvld_ff      <= 1'b0;
         zvld_ff      <= 1'b0;
         pvld_ff      <= 1'b0;
         qvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         svld_ff      <= dvld_ff[QW];
         yvld_ff      <= svld_ff;
         zvld_ff      <= yvld_ff;
         pvld_ff      <= zvld_ff;
         qvld_ff      <= pvld_ff;
         rsp_valid_ff <= qvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ax = 0; ax < 3; ax++) begin
            slab_ff[ax] <= slab_in[ax];
         end
         smiss_ff <= smiss_in;
         sray_ff  <= dray_ff[QW];
         ym_ff    <= ym_in;
         yz_ff    <= slab_ff[2];
         yray_ff  <= sray_ff;
         zm_ff    <= zm_in;
         ztsat_ff <= ztsat_in;
         zray_ff  <= yray_ff;
         prod_ff  <= prod_in;
         pneg_ff  <= pneg_in;
         pm_ff    <= zm_ff;
         pray_ff  <= zray_ff;
         for (int ax = 0; ax < 3; ax++) begin
            off_ff[ax] <= off_in[ax];
         end
         qm_ff      <= pm_ff;
         qray_ff    <= pray_ff;
         rsp_hit_ff <= !qm_ff.miss;
         for (int ax = 0; ax < 3; ax++) begin
            rsp_pt_ff[ax]  <= pt_in[ax];
            rsp_nrm_ff[ax] <= qm_ff.miss ? NRM_NONE : qm_ff.nrm[ax];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_point_x = rsp_pt_ff[0];
   assign rsp_hit_point_y = rsp_pt_ff[1];
   assign rsp_hit_point_z = rsp_pt_ff[2];
   assign rsp_normal_x    = rsp_nrm_ff[0];
   assign rsp_normal_y    = rsp_nrm_ff[1];
   assign rsp_normal_z    = rsp_nrm_ff[2];

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_point_x == '0 && rsp_hit_point_y == '0 &&
         rsp_hit_point_z == '0 && rsp_normal_x == NRM_NONE &&
         rsp_normal_y == NRM_NONE && rsp_normal_z == NRM_NONE)
      else $error("miss result carries nonzero fields");

   a_one_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $onehot({rsp_normal_x != NRM_NONE,
         rsp_normal_y != NRM_NONE, rsp_normal_z != NRM_NONE}))
      else $error("hit result does not name exactly one entry face");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(qvld_ff) && $stable(pvld_ff) && $stable(dvld_ff[0]))
      else $error("pipeline moved while the result was stalled");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while the output is stalled");

endmodule

/* sim/rbsi_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for ray_box_slab_intersection: tracks box register writes, predicts each ray.
// It compares every result word against the prediction. Depends on rbsi_pkg for widths.
module rbsi_checker
   import rbsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CW-1:0]     req_origin_x,
   input  logic [CW-1:0]     req_origin_y,
   input  logic [CW-1:0]     req_origin_z,
   input  logic [CW-1:0]     req_dir_x,
   input  logic [CW-1:0]     req_dir_y,
   input  logic [CW-1:0]     req_dir_z,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_hit,
   input  logic [CW-1:0]     rsp_hit_point_x,
   input  logic [CW-1:0]     rsp_hit_point_y,
   input  logic [CW-1:0]     rsp_hit_point_z,
   input  logic [1:0]        rsp_normal_x,
   input  logic [1:0]        rsp_normal_y,
   input  logic [1:0]        rsp_normal_z,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CW-1:0]     pwdata,
   output int                mismatches,
   output int                pending
);

   typedef struct packed {
      logic          hit;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] pz;
      logic [1:0]    nx;
      logic [1:0]    ny;
      logic [1:0]    nz;
   } box_hit_type;

   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;

   logic [CW-1:0] box_corner[6];
   box_hit_type   hit_queue[$];

   function automatic longint clamp_coord(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Fixed-point quotient of magnitudes, truncated toward zero, saturated.
   function automatic longint slab_distance(longint num, longint den);
      logic neg;
      longint unsigned an, ad, ip, rem, q;
      neg = (num < 0) != (den < 0);
      an = magnitude(num);
      ad = magnitude(den);
      ip = an / ad;
      rem = an % ad;
      if (ip >= (64'd1 << (CW - 1 - FB))) return neg ? CMIN : CMAX;
      q = (ip << FB) | ((rem << FB) / ad);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint scaled_step(longint d, longint t);
      logic neg;
      longint unsigned m;
      neg = (d < 0) != (t < 0);
      m = (magnitude(d) * magnitude(t)) >> FB;
      if (m > (64'd1 << CW)) m = 64'd1 << CW;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic box_hit_type trace_ray(logic [CW-1:0] org_in[3],
                                             logic [CW-1:0] dir_in[3]);
      box_hit_type r;
      longint o[3], d[3], lo, hi, tn, tf, tmin, tmax, t, p, sw;
      int nrm[3], s;
      r = '0;
      tmin = 0;
      tmax = 0;
      nrm = '{0, 0, 0};
      for (int ax = 0; ax < 3; ax++) begin
         o[ax] = longint'(signed'(org_in[ax]));
         d[ax] = longint'(signed'(dir_in[ax]));
      end
      for (int ax = 0; ax < 3; ax++) begin
         lo = longint'(signed'(box_corner[ax]));
         hi = longint'(signed'(box_corner[3 + ax]));
         s = -1;
         if (d[ax] == 0) begin
            // A parallel slab either misses outright or spans every distance.
            if (o[ax] < lo || o[ax] > hi) return r;
            tn = CMIN - 1;
            tf = CMAX + 1;
         end else begin
            tn = slab_distance(lo - o[ax], d[ax]);
            tf = slab_distance(hi - o[ax], d[ax]);
            if (tn > tf) begin
               sw = tn;
               tn = tf;
               tf = sw;
               s = 1;
            end
         end
         if (ax == 0) begin
            tmin = tn;
            tmax = tf;
            nrm[0] = s;
         end else begin
            if (tmin > tf || tn > tmax) return r;
            if (tn > tmin) begin
               tmin = tn;
               nrm = '{0, 0, 0};
               nrm[ax] = s;
            end
            if (tf < tmax) tmax = tf;
         end
      end
      t = clamp_coord(tmin);
      r.hit = 1'b1;
      p = (d[0] == 0) ? 0 : scaled_step(d[0], t);
      r.px = CW'(clamp_coord(o[0] + p));
      p = (d[1] == 0) ? 0 : scaled_step(d[1], t);
      r.py = CW'(clamp_coord(o[1] + p));
      p = (d[2] == 0) ? 0 : scaled_step(d[2], t);
      r.pz = CW'(clamp_coord(o[2] + p));
      r.nx = 2'(nrm[0]);
      r.ny = 2'(nrm[1]);
      r.nz = 2'(nrm[2]);
      return r;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   assign pending = hit_queue.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      box_hit_type want;
      logic [CW-1:0] org_w[3];
      logic [CW-1:0] dir_w[3];
      if (reset) begin
         for (int i = 0; i < 6; i++) box_corner[i] = '0;
         hit_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] < 3'd6))
            box_corner[paddr[ADDR_W-1:2]] = pwdata;
         if (req_valid && !req_stall) begin
            org_w = '{req_origin_x, req_origin_y, req_origin_z};
            dir_w = '{req_dir_x, req_dir_y, req_dir_z};
            hit_queue.push_back(trace_ray(org_w, dir_w));
         end
         if (rsp_valid && !rsp_stall) begin
            if (hit_queue.size() == 0) begin
               $error("result word arrived with no ray outstanding");
               mismatches++;
            end else begin
               want = hit_queue.pop_front();
               compare_field("hit", longint'(want.hit), longint'(rsp_hit));
               compare_field("hit_point_x", longint'(want.px), longint'(rsp_hit_point_x));
               compare_field("hit_point_y", longint'(want.py), longint'(rsp_hit_point_y));
               compare_field("hit_point_z", longint'(want.pz), longint'(rsp_hit_point_z));
               compare_field("normal_x", longint'(want.nx), longint'(rsp_normal_x));
               compare_field("normal_y", longint'(want.ny), longint'(rsp_normal_y));
               compare_field("normal_z", longint'(want.nz), longint'(rsp_normal_z));
            end
         end
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for ray_box_slab_intersection: clock, reset, ray stimulus and verdict.
// Depends on rbsi_pkg, the block itself and rbsi_checker.
module tb;
   import rbsi_pkg::*;

   localparam int LATENCY    = 38;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_RAYS = 250;
   localparam longint ONE    = 64'sd65536;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CW-1:0]     req_origin_x, req_origin_y, req_origin_z;
   logic [CW-1:0]     req_dir_x, req_dir_y, req_dir_z;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_hit;
   logic [CW-1:0]     rsp_hit_point_x, rsp_hit_point_y, rsp_hit_point_z;
   logic [1:0]        rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic              psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [CW-1:0]     pwdata;
   logic [CW-1:0]     prdata;
   logic              pready;

   int   mismatches;
   int   pending;
   logic req_taken;
   logic quiet;          // when set, neither side idles
   logic hold_request;   // asks the receiver for one long hold-off
   int   stuck_cycles;
   longint box_lo[3], box_hi[3];

   ray_box_slab_intersection u_top (.*);

   rbsi_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The request acceptance is captured at the clock edge so that the sender
   // can act on it at the following falling edge without any race.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // The watchdog ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // The receiver stalls in random bursts, and once holds off for a long
   // stretch so that the pipeline fills and back-pressure reaches the input.
   initial begin
      int hold_left;
      int burst_left;
      hold_left = 0;
      burst_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_request = 1'b0;
         end else if (hold_request) begin
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 10) - 1;
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
      end
   end

   task automatic write_reg(reg_idx_type idx, longint value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= CW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_box(longint lx, longint ly, longint lz,
                           longint hx, longint hy, longint hz);
      write_reg(REG_MIN_X, lx);
      write_reg(REG_MIN_Y, ly);
      write_reg(REG_MIN_Z, lz);
      write_reg(REG_MAX_X, hx);
      write_reg(REG_MAX_Y, hy);
      write_reg(REG_MAX_Z, hz);
      box_lo = '{lx, ly, lz};
      box_hi = '{hx, hy, hz};
   endtask

   // Offers one ray and returns at the falling edge after it was taken. The
   // valid stays high when the next ray follows without a gap.
   task automatic send_ray(longint ox, longint oy, longint oz,
                           longint dx, longint dy, longint dz);
      req_valid <= 1'b1;
      req_origin_x <= CW'(ox);
      req_origin_y <= CW'(oy);
      req_origin_z <= CW'(oz);
      req_dir_x <= CW'(dx);
      req_dir_y <= CW'(dy);
      req_dir_z <= CW'(dz);
      do @(negedge clock); while (!req_taken);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   function automatic longint any_word();
      return longint'(signed'(32'($urandom())));
   endfunction

   // Mostly rays aimed at a point inside the box, with zero direction
   // components mixed in; the rest are raw words over the whole range.
   task automatic random_ray(output longint o[3], output longint d[3]);
      longint span, target;
      int pick;
      pick = $urandom_range(0, 9);
      for (int ax = 0; ax < 3; ax++) begin
         if (pick >= 7) begin
            o[ax] = any_word();
            d[ax] = ($urandom_range(0, 7) == 0) ? 0 : any_word();
         end else begin
            span = box_hi[ax] - box_lo[ax];
            if (span < 0) span = -span;
            target = (box_lo[ax] < box_hi[ax] ? box_lo[ax] : box_hi[ax])
                     + ((span == 0) ? 0 : longint'({$urandom(), $urandom()} % span));
            o[ax] = target + longint'(signed'(32'($urandom()))) / (1 << $urandom_range(4, 12));
            if (o[ax] > 64'sd2147483647 || o[ax] < -64'sd2147483648) o[ax] = target;
            d[ax] = (target - o[ax]) >>> $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) d[ax] = 0;
            if (d[ax] > 64'sd2147483647 || d[ax] < -64'sd2147483648) d[ax] = any_word();
         end
      end
   endtask

   task automatic random_phase(int count, logic with_hold);
      longint o[3], d[3];
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == 40) hold_request = 1'b1;
         random_ray(o, d);
         send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
      end
      drain();
   endtask

   initial begin
      longint lo, hi;
      reset <= 1'b1;
      quiet = 1'b0;
      hold_request = 1'b0;
      req_valid <= 1'b0;
      req_origin_x <= '0;
      req_origin_y <= '0;
      req_origin_z <= '0;
      req_dir_x <= '0;
      req_dir_y <= '0;
      req_dir_z <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rays against a small box around the origin.
      load_box(-ONE, -2 * ONE, -3 * ONE, 2 * ONE, 3 * ONE, 4 * ONE);
      send_ray(-10 * ONE, 0, 0, ONE, 0, 0);           // along +x, enters the min x face
      send_ray(10 * ONE, 0, 0, -ONE, 0, 0);           // along -x, enters the max x face
      send_ray(0, -10 * ONE, 0, 0, ONE, 0);
      send_ray(0, 10 * ONE, 0, 0, -ONE, 0);
      send_ray(0, 0, -10 * ONE, 0, 0, ONE);
      send_ray(0, 0, 10 * ONE, 0, 0, -ONE);
      send_ray(0, 0, 0, ONE, ONE, ONE);               // origin inside: negative entry distance
      send_ray(0, 0, 0, 0, 0, 0);                     // no direction at all, inside the box
      send_ray(5 * ONE, 0, 0, 0, ONE, 0);             // parallel to x and outside that slab
      send_ray(-5 * ONE, 0, 0, 0, ONE, 0);
      send_ray(-10 * ONE, 10 * ONE, 0, ONE, 0, 0);    // parallel to y and outside that slab
      send_ray(-10 * ONE, 20 * ONE, 0, ONE, -ONE, 0); // disjoint after merging y
      send_ray(-10 * ONE, -10 * ONE, -10 * ONE, ONE, ONE, ONE);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1); // tiny steps saturate
      send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_ray(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0);
      send_ray(32'h7fff_ffff, 0, 0, -1, 0, 0);
      send_ray(-ONE, 0, 0, 0, 0, 0);                  // on the min x face, no direction
      send_ray(2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0);   // on the max corner
      send_ray(-20 * ONE, 1, 1, 32'h7fff_ffff, 1, -1);
      drain();

      // Inverted box: swaps flip the normal and a parallel slab always misses.
      load_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
      send_ray(-10 * ONE, 0, 0, ONE, ONE, ONE);
      send_ray(0, 0, 0, 0, ONE, ONE);
      drain();

      random_phase(PHASE_RAYS, 1'b1);

      load_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
               64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
      random_phase(PHASE_RAYS, 1'b0);

      load_box(3 * ONE, 2 * ONE, ONE, -3 * ONE, -2 * ONE, -ONE);
      random_phase(PHASE_RAYS, 1'b0);

      for (int ax = 0; ax < 3; ax++) begin
         lo = any_word();
         hi = any_word();
         if (lo > hi) begin
            box_lo[ax] = hi;
            box_hi[ax] = lo;
         end else begin
            box_lo[ax] = lo;
            box_hi[ax] = hi;
         end
      end
      load_box(box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2]);
      random_phase(PHASE_RAYS, 1'b0);

      load_box(ONE, ONE, ONE, ONE, ONE, ONE);         // a single point
      random_phase(PHASE_RAYS / 2, 1'b0);

      // Closing stretch runs with both sides always ready.
      load_box(-7 * ONE, -ONE / 2, -9 * ONE, 5 * ONE, 11 * ONE, ONE / 4);
      quiet = 1'b1;
      random_phase(PHASE_RAYS, 1'b0);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
src/rbsi_pkg.sv
src/ray_box_slab_intersection.sv
sim/rbsi_checker.sv
sim/tb.sv
